[hdl/nlba_pkg.sv]
// ----------------------------------------------------------------------------
// nlba_pkg
// Shared types and constants of the notification light arbiter: slot codes,
// register indexes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package nlba_pkg;

    // field widths
    localparam int COLOR_W  = 24;
    localparam int TIME_W   = 16;
    localparam int TOTAL_W  = 17;
    localparam int UNIT_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int DIVD_W   = 24;
    localparam int CNT_W    = 5;

    // slot codes carried by opcode
    localparam logic [1:0] SLOT_BATTERY      = 2'd0;
    localparam logic [1:0] SLOT_NOTIFICATION = 2'd1;
    localparam logic [1:0] SLOT_ATTENTION    = 2'd2;
    // opcode that rewrites no slot and only reports the current display
    localparam logic [1:0] OP_REPORT         = 2'd3;

    // shown slot codes
    localparam logic [1:0] SHOWN_NONE         = 2'd0;
    localparam logic [1:0] SHOWN_BATTERY      = 2'd1;
    localparam logic [1:0] SHOWN_NOTIFICATION = 2'd2;
    localparam logic [1:0] SHOWN_ATTENTION    = 2'd3;

    // configuration register indexes
    localparam logic CFG_FREQ_UNIT = 1'b0;
    localparam logic CFG_PWM_FLOOR = 1'b1;

    // register reset values
    localparam logic [UNIT_W-1:0] FREQ_UNIT_RESET = 10'd50;
    localparam logic [BYTE_W-1:0] PWM_FLOOR_RESET = 8'd16;

    // divider step counts for the two quotients
    localparam logic [CNT_W-1:0] FREQ_STEPS = 5'd17;
    localparam logic [CNT_W-1:0] PWM_STEPS  = 5'd24;

    // controller to datapath commands
    typedef struct packed {
        logic wr_slot;
        logic sel_cap;
        logic load_freq;
        logic load_pwm;
        logic div_step;
        logic freq_cap;
        logic pwm_cap;
        logic out_cap;
    } nlba_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic blink;
        logic div_done;
    } nlba_status_t;

endpackage

[hdl/notification_led_blink_arbiter_unit.sv]
// ----------------------------------------------------------------------------
// notification_led_blink_arbiter_unit
// Keeps battery, notification and attention light requests and reports the
// colour and blink settings of the highest-priority lit one.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode, color, flash_timed, on_ms, off_ms) is taken at a
//   clock edge with start high and busy low. It rewrites one slot; opcode
//   three rewrites none and just reports the current state.
//   One result per request appears on red/green/blue/blink/freq/pwm/
//   shown_slot for a single cycle with done high. The receiver cannot
//   stall; the result must be taken in that cycle. Configuration (cfg_we,
//   cfg_index, cfg_wdata) is for the user to write only while busy is low;
//   the block does not check it. Index 0: frequency unit in ms, 1: duty floor.
// Timing:
//   Steady or unlit result: done rises after the SEL, CHK and FIN states.
//   Blinking result: FRUN and PRUN lie between CHK and FIN; the shared divider
//   produces one quotient bit per cycle: 17 bits for freq, then 24 for pwm.
//   busy is low in the done cycle, so the next request can be taken at the
//   edge that ends it; no request is taken while one is in progress.
// Reset:
//   All slots clear (nothing lit), unit 50 ms, duty floor 16, result ports
//   zero, controller idle.
// ----------------------------------------------------------------------------
module notification_led_blink_arbiter_unit
    import nlba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [COLOR_W-1:0]  color,
    input  logic                flash_timed,
    input  logic [TIME_W-1:0]   on_ms,
    input  logic [TIME_W-1:0]   off_ms,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [UNIT_W-1:0]   cfg_wdata,
    output logic                done,
    output logic [BYTE_W-1:0]   red,
    output logic [BYTE_W-1:0]   green,
    output logic [BYTE_W-1:0]   blue,
    output logic                blink,
    output logic [TOTAL_W-1:0]  freq,
    output logic [BYTE_W-1:0]   pwm,
    output logic [1:0]          shown_slot
);

    nlba_cmd_t    cmd;
    nlba_status_t status;

    // sequencer
    nlba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // storage, divider and results
    nlba_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .opcode      (opcode),
        .color       (color),
        .flash_timed (flash_timed),
        .on_ms       (on_ms),
        .off_ms      (off_ms),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .blink       (blink),
        .freq        (freq),
        .pwm         (pwm),
        .shown_slot  (shown_slot)
    );

    // an accepted transaction keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the result strobe lasts one cycle and comes with the block free again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy ##1 !done))
        else $error("done strobe longer than one cycle or while busy");

    // steady result carries no blink settings
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !blink) |-> (freq == '0 && pwm == '0))
        else $error("blink settings reported for a steady result");

    // nothing lit means black and no blinking
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && shown_slot == SHOWN_NONE) |->
            (red == '0 && green == '0 && blue == '0 && !blink))
        else $error("unlit result carries a colour");

endmodule

[hdl/nlba_ctrl.sv]
// ----------------------------------------------------------------------------
// nlba_ctrl
// Sequencer of the arbiter: slot write, selection, then the two divisions
// on the shared divider when the shown slot blinks, then the result strobe.
// ----------------------------------------------------------------------------
module nlba_ctrl
    import nlba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  nlba_status_t status,
    output nlba_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_FRUN = 3'd3;
    localparam logic [2:0] ST_PRUN = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.wr_slot = 1'b1;
                    state_next  = ST_SEL;
                end
            end
            ST_SEL:
            begin
                cmd.sel_cap = 1'b1;
                state_next  = ST_CHK;
            end
            ST_CHK:
            begin
                if (status.blink)
                begin
                    cmd.load_freq = 1'b1;
                    state_next    = ST_FRUN;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FRUN:
            begin
                if (status.div_done)
                begin
                    cmd.freq_cap = 1'b1;
                    cmd.load_pwm = 1'b1;
                    state_next   = ST_PRUN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PRUN:
            begin
                if (status.div_done)
                begin
                    cmd.pwm_cap = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.out_cap = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_next = (state_reg == ST_FIN);

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[hdl/nlba_datapath.sv]
// ----------------------------------------------------------------------------
// nlba_datapath
// Slot storage, configuration registers, priority selection, a shared
// restoring divider (one quotient bit per cycle) and the result registers.
// ----------------------------------------------------------------------------
module nlba_datapath
    import nlba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  nlba_cmd_t           cmd,
    output nlba_status_t        status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [UNIT_W-1:0]   cfg_wdata,
    input  logic [1:0]          opcode,
    input  logic [COLOR_W-1:0]  color,
    input  logic                flash_timed,
    input  logic [TIME_W-1:0]   on_ms,
    input  logic [TIME_W-1:0]   off_ms,
    output logic [BYTE_W-1:0]   red,
    output logic [BYTE_W-1:0]   green,
    output logic [BYTE_W-1:0]   blue,
    output logic                blink,
    output logic [TOTAL_W-1:0]  freq,
    output logic [BYTE_W-1:0]   pwm,
    output logic [1:0]          shown_slot
);

    // configuration
    logic [UNIT_W-1:0]  freq_unit_reg;
    logic [BYTE_W-1:0]  pwm_floor_reg;

    // slots
    logic [COLOR_W-1:0] slot_color_reg [3];
    logic               slot_timed_reg [3];
    logic [TIME_W-1:0]  slot_on_reg    [3];
    logic [TIME_W-1:0]  slot_off_reg   [3];
    logic [COLOR_W-1:0] wr_color;

    // selection
    logic [1:0]         sel_idx;
    logic [1:0]         sel_shown;
    logic [COLOR_W-1:0] sel_color_reg;
    logic [1:0]         sel_shown_reg;
    logic               sel_blink_reg;
    logic [TIME_W-1:0]  sel_on_reg;
    logic [TOTAL_W-1:0] sel_total_reg;
    logic               sel_blink;

    // divider
    logic [TOTAL_W-1:0] rem_reg;
    logic [DIVD_W-1:0]  quo_reg;
    logic [TOTAL_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TOTAL_W:0]   shifted;
    logic [TOTAL_W:0]   trial;
    logic [DIVD_W-1:0]  on_x255;
    logic [TOTAL_W-1:0] unit_eff;

    // quotients and results
    logic [TOTAL_W-1:0] freq_q_reg;
    logic [BYTE_W-1:0]  pwm_q_reg;
    logic [BYTE_W-1:0]  pwm_raw;
    logic [BYTE_W-1:0]  pwm_floored;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_blink_reg;
    logic [TOTAL_W-1:0] out_freq_reg;
    logic [BYTE_W-1:0]  out_pwm_reg;
    logic [1:0]         out_shown_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_unit_reg <= FREQ_UNIT_RESET;
            pwm_floor_reg <= PWM_FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FREQ_UNIT: freq_unit_reg <= cfg_wdata;
                CFG_PWM_FLOOR: pwm_floor_reg <= cfg_wdata[BYTE_W-1:0];
                default:       freq_unit_reg <= freq_unit_reg;
            endcase
        end
    end

    // attention with both times zero is switched off
    assign wr_color = (opcode == SLOT_ATTENTION && on_ms == '0 && off_ms == '0)
                      ? '0 : color;

    // slot write, opcode three writes nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slot_color_reg[i] <= '0;
                slot_timed_reg[i] <= 1'b0;
                slot_on_reg[i]    <= '0;
                slot_off_reg[i]   <= '0;
            end
        end
        else if (cmd.wr_slot && opcode != OP_REPORT)
        begin
            slot_color_reg[opcode] <= wr_color;
            slot_timed_reg[opcode] <= flash_timed;
            slot_on_reg[opcode]    <= on_ms;
            slot_off_reg[opcode]   <= off_ms;
        end
    end

    // priority pick: attention, notification, battery
    always_comb
    begin
        sel_idx   = SLOT_BATTERY;
        sel_shown = SHOWN_NONE;
        if (slot_color_reg[SLOT_ATTENTION] != '0)
        begin
            sel_idx   = SLOT_ATTENTION;
            sel_shown = SHOWN_ATTENTION;
        end
        else if (slot_color_reg[SLOT_NOTIFICATION] != '0)
        begin
            sel_idx   = SLOT_NOTIFICATION;
            sel_shown = SHOWN_NOTIFICATION;
        end
        else if (slot_color_reg[SLOT_BATTERY] != '0)
        begin
            sel_idx   = SLOT_BATTERY;
            sel_shown = SHOWN_BATTERY;
        end
    end

    assign sel_blink = (sel_shown != SHOWN_NONE) && slot_timed_reg[sel_idx]
                       && (slot_on_reg[sel_idx] != '0) && (slot_off_reg[sel_idx] != '0);

    // capture the shown slot
    always_ff @(posedge clk)
    begin
        if (cmd.sel_cap)
        begin
            sel_color_reg <= (sel_shown == SHOWN_NONE) ? '0 : slot_color_reg[sel_idx];
            sel_shown_reg <= sel_shown;
            sel_blink_reg <= sel_blink;
            sel_on_reg    <= slot_on_reg[sel_idx];
            sel_total_reg <= {1'b0, slot_on_reg[sel_idx]} + {1'b0, slot_off_reg[sel_idx]};
        end
    end

    // divider operands: on*255 as (on << 8) - on, unit zero counts as one
    assign on_x255  = {sel_on_reg, 8'd0} - {8'd0, sel_on_reg};
    assign unit_eff = (freq_unit_reg == '0) ? 17'd1 : {7'd0, freq_unit_reg};

    // one restoring step
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};

    // shared divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_freq)
        begin
            cnt_reg <= FREQ_STEPS;
        end
        else if (cmd.load_pwm)
        begin
            cnt_reg <= PWM_STEPS;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_freq)
        begin
            rem_reg  <= '0;
            quo_reg  <= {sel_total_reg, 7'd0};
            dvsr_reg <= unit_eff;
        end
        else if (cmd.load_pwm)
        begin
            rem_reg  <= '0;
            quo_reg  <= on_x255;
            dvsr_reg <= sel_total_reg;
        end
        else if (cmd.div_step)
        begin
            if (!trial[TOTAL_W])
            begin
                rem_reg <= trial[TOTAL_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[TOTAL_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    // quotient capture
    always_ff @(posedge clk)
    begin
        if (cmd.freq_cap)
        begin
            freq_q_reg <= quo_reg[TOTAL_W-1:0];
        end
        if (cmd.pwm_cap)
        begin
            pwm_q_reg <= quo_reg[BYTE_W-1:0];
        end
    end

    // duty floor
    assign pwm_raw     = pwm_q_reg;
    assign pwm_floored = (pwm_raw != '0 && pwm_raw < pwm_floor_reg) ? pwm_floor_reg : pwm_raw;

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_color_reg <= '0;
            out_blink_reg <= 1'b0;
            out_freq_reg  <= '0;
            out_pwm_reg   <= '0;
            out_shown_reg <= SHOWN_NONE;
        end
        else if (cmd.out_cap)
        begin
            out_color_reg <= sel_color_reg;
            out_blink_reg <= sel_blink_reg;
            out_freq_reg  <= sel_blink_reg ? freq_q_reg : '0;
            out_pwm_reg   <= sel_blink_reg ? pwm_floored : '0;
            out_shown_reg <= sel_shown_reg;
        end
    end

    assign status.blink    = sel_blink_reg;
    assign status.div_done = (cnt_reg == '0);

    assign red        = out_color_reg[23:16];
    assign green      = out_color_reg[15:8];
    assign blue       = out_color_reg[7:0];
    assign blink      = out_blink_reg;
    assign freq       = out_freq_reg;
    assign pwm        = out_pwm_reg;
    assign shown_slot = out_shown_reg;

endmodule
